[rtl/pds_pkg.sv]
// Shared types and constants for the PLL divider search block.
package pds_pkg;

  localparam int REF_W  = 30;
  localparam int GOAL_W = 30;
  // ref >= 1 MHz > 2^19, so goal/ref stays below 2^11
  localparam int QG_W   = GOAL_W - 19;

  localparam int unsigned VIN_LO_HZ    = 32'd1_000_000;
  localparam int unsigned VIN_HI_HZ    = 32'd25_000_000;
  localparam int unsigned VCO_LO_HZ    = 32'd240_000_000;
  localparam int unsigned VCO_HI_HZ    = 32'd480_000_000;
  localparam int unsigned MUL_MIN      = 32'd20;
  localparam int unsigned POST_DIV_MIN = 32'd2;

  typedef struct packed {
    logic [REF_W-1:0]  ref_hz;
    logic [GOAL_W-1:0] goal_hz;
  } in_t;

  typedef struct packed {
    logic       found;
    logic [4:0] pre_div;
    logic [8:0] vco_mul;
    logic [4:0] post_div;
  } out_t;

  // remainder side of one step: (lhs + rhs) reduced once modulo dvs
  typedef struct packed {
    logic [REF_W:0]   lhs;
    logic [REF_W-1:0] rhs;
    logic [REF_W-1:0] dvs;
  } rem_req_t;

endpackage

[rtl/pds_step_unit.sv]
// Shared add / reduce unit: one division step or one quotient-remainder accumulate.
module pds_step_unit #(
  parameter int Q_W = 21
) (
  input  pds_pkg::rem_req_t         req,
  input  logic [Q_W-1:0]            quo_a,
  input  logic [Q_W-1:0]            quo_b,
  output logic [pds_pkg::REF_W-1:0] rem,
  output logic [Q_W-1:0]            quo
);

  logic [pds_pkg::REF_W:0] sum;
  logic                    ge;

  always_comb begin
    sum = req.lhs + {1'b0, req.rhs};
    ge  = (sum >= {1'b0, req.dvs});
    if (ge) begin
      rem = pds_pkg::REF_W'(sum - {1'b0, req.dvs});
    end else begin
      rem = sum[pds_pkg::REF_W-1:0];
    end
    quo = quo_a + quo_b + Q_W'(ge);
  end

endmodule

[rtl/pll_divider_search.sv]
// PLL divider search top level: sequencer and registers around the shared step unit.
// Accept to result beat: the search ends at the first match, or once every M and P is tried;
//   a ref below 1 MHz skips the search and gives a miss.
// Throughput: one beat at a time; in_stall is high from accept until the result is loaded.
// Per-M cost is set by the P loop through the single step unit (one P per cycle).
// Reset: synchronous, active low; clears sequencer state, the found flag and output valid only.
module pll_divider_search #(
  parameter int PRE_DIV_MAX  = 24,
  parameter int MUL_MAX      = 480,
  parameter int POST_DIV_MAX = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  pds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pds_pkg::out_t  out_data
);

  // Method: with N = goal*M*P/ref, VCO = goal*P. For each M, P climbs and the quotient
  // and remainder of goal*M*P by ref are kept incrementally, so N rises with P and the
  // first P that divides exactly with N and VCO in range is the first match in M,N,P order.
  // goal/ref itself is found once by a restoring divide over QG_W steps.

  localparam int M_W  = $clog2(PRE_DIV_MAX + 1);
  localparam int P_W  = $clog2(POST_DIV_MAX + 1);
  localparam int QD_W = pds_pkg::QG_W + M_W;
  localparam int Q_W  = QD_W + P_W;
  localparam int V_W  = pds_pkg::GOAL_W + P_W;
  localparam int HI_W = $clog2(64'(pds_pkg::VIN_HI_HZ) * PRE_DIV_MAX + 1);
  localparam int R_W  = pds_pkg::REF_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MSTEP = 3'd2;
  localparam logic [2:0] S_PLOOP = 3'd3;
  localparam logic [2:0] S_MNEXT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_r, state_nxt;
  logic [R_W-1:0]         ref_r, ref_nxt;
  logic [pds_pkg::GOAL_W-1:0] goal_r, goal_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic [Q_W-1:0]         q_r, q_nxt;
  logic [R_W-1:0]         r_r, r_nxt;
  logic [pds_pkg::QG_W-1:0] qg_r, qg_nxt;
  logic [R_W-1:0]         rg_r, rg_nxt;
  logic [QD_W-1:0]        qd_r, qd_nxt;
  logic [R_W-1:0]         rd_r, rd_nxt;
  logic [V_W-1:0]         v_r, v_nxt;
  logic [M_W-1:0]         m_r, m_nxt;
  logic [P_W-1:0]         p_r, p_nxt;
  logic [HI_W-1:0]        lo_r, lo_nxt;
  logic [HI_W-1:0]        hi_r, hi_nxt;
  logic                   found_r, found_nxt;
  pds_pkg::out_t          out_data_r, out_data_nxt;
  logic                   out_valid_r, out_valid_nxt;

  pds_pkg::rem_req_t      su_req;
  logic [Q_W-1:0]         su_qa, su_qb, su_quo;
  logic [R_W-1:0]         su_rem;

  logic                   in_acc;
  logic                   vin_ok;
  logic                   cand_ok;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  pds_step_unit #(.Q_W(Q_W)) u_step (
    .req   (su_req),
    .quo_a (su_qa),
    .quo_b (su_qb),
    .rem   (su_rem),
    .quo   (su_quo)
  );

  // step unit operand select
  always_comb begin
    su_req = '0;
    su_qa  = '0;
    su_qb  = '0;
    case (state_r)
      S_DIV: begin
        su_req.lhs = {r_r, goal_r[cnt_r]};
        su_req.dvs = ref_r;
        su_qa      = {q_r[Q_W-2:0], 1'b0};
      end
      S_PLOOP: begin
        su_req.lhs = {1'b0, r_r};
        su_req.rhs = rd_r;
        su_req.dvs = ref_r;
        su_qa      = q_r;
        su_qb      = Q_W'(qd_r);
      end
      S_MNEXT: begin
        su_req.lhs = {1'b0, rd_r};
        su_req.rhs = rg_r;
        su_req.dvs = ref_r;
        su_qa      = Q_W'(qd_r);
        su_qb      = Q_W'(qg_r);
      end
      default: begin
        su_req = '0;
      end
    endcase
  end

  // VCO input window for the current M
  assign vin_ok = (64'(ref_r) >= 64'(lo_r)) && (64'(ref_r) <= 64'(hi_r));

  // P at least POST_DIV_MIN, exact divide, N in range, VCO (= goal*P) in range
  assign cand_ok = (p_r >= P_W'(pds_pkg::POST_DIV_MIN)) && (r_r == '0)
                && (q_r >= Q_W'(pds_pkg::MUL_MIN)) && (q_r <= Q_W'(MUL_MAX))
                && (v_r >= V_W'(pds_pkg::VCO_LO_HZ)) && (v_r <= V_W'(pds_pkg::VCO_HI_HZ));

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    goal_nxt      = goal_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    r_nxt         = r_r;
    qg_nxt        = qg_r;
    rg_nxt        = rg_r;
    qd_nxt        = qd_r;
    rd_nxt        = rd_r;
    v_nxt         = v_r;
    m_nxt         = m_r;
    p_nxt         = p_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    found_nxt     = found_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ref_nxt   = in_data.ref_hz;
          goal_nxt  = in_data.goal_hz;
          r_nxt     = R_W'(in_data.goal_hz >> pds_pkg::QG_W);
          q_nxt     = '0;
          cnt_nxt   = 5'(pds_pkg::QG_W - 1);
          m_nxt     = M_W'(1);
          lo_nxt    = HI_W'(pds_pkg::VIN_LO_HZ);
          hi_nxt    = HI_W'(pds_pkg::VIN_HI_HZ);
          found_nxt = 1'b0;
          // below 1 MHz no M can pass the input window
          if (in_data.ref_hz < R_W'(pds_pkg::VIN_LO_HZ)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        q_nxt   = su_quo;
        r_nxt   = su_rem;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          qg_nxt    = pds_pkg::QG_W'(su_quo);
          rg_nxt    = su_rem;
          qd_nxt    = QD_W'(su_quo);
          rd_nxt    = su_rem;
          state_nxt = S_MSTEP;
        end
      end
      S_MSTEP: begin
        if (vin_ok) begin
          q_nxt     = Q_W'(qd_r);
          r_nxt     = rd_r;
          v_nxt     = V_W'(goal_r);
          p_nxt     = P_W'(1);
          state_nxt = S_PLOOP;
        end else begin
          state_nxt = S_MNEXT;
        end
      end
      S_PLOOP: begin
        if (cand_ok) begin
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (p_r == P_W'(POST_DIV_MAX)) begin
          state_nxt = S_MNEXT;
        end else begin
          q_nxt = su_quo;
          r_nxt = su_rem;
          v_nxt = v_r + V_W'(goal_r);
          p_nxt = p_r + P_W'(1);
        end
      end
      S_MNEXT: begin
        if (m_r == M_W'(PRE_DIV_MAX)) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          qd_nxt    = QD_W'(su_quo);
          rd_nxt    = su_rem;
          m_nxt     = m_r + M_W'(1);
          lo_nxt    = lo_r + HI_W'(pds_pkg::VIN_LO_HZ);
          hi_nxt    = hi_r + HI_W'(pds_pkg::VIN_HI_HZ);
          state_nxt = S_MSTEP;
        end
      end
      S_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_r || !out_stall) begin
          if (found_r) begin
            out_data_nxt.found    = 1'b1;
            out_data_nxt.pre_div  = 5'(m_r);
            out_data_nxt.vco_mul  = 9'(q_r);
            out_data_nxt.post_div = 5'(p_r);
          end else begin
            out_data_nxt = '0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_r      <= ref_nxt;
    goal_r     <= goal_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    r_r        <= r_nxt;
    qg_r       <= qg_nxt;
    rg_r       <= rg_nxt;
    qd_r       <= qd_nxt;
    rd_r       <= rd_nxt;
    v_r        <= v_nxt;
    m_r        <= m_nxt;
    p_r        <= p_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  // an accepted beat always takes the block out of idle (a search, or straight to a miss below 1 MHz)
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("search did not start after accept");

  // a miss reports all-zero dividers
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.pre_div == '0 && out_data_r.vco_mul == '0 && out_data_r.post_div == '0))
    else $error("not-found result carries nonzero fields");

  // divide remainder stays reduced
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (r_r < ref_r))
    else $error("division remainder not below ref");

  // per-M step remainders stay reduced
  a_m_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MSTEP || state_r == S_PLOOP || state_r == S_MNEXT) |->
      (rd_r < ref_r && rg_r < ref_r))
    else $error("per-M remainder not below ref");

  // P loop keeps a reduced remainder and a nonzero P
  a_p_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLOOP) |-> (r_r < ref_r && p_r != '0))
    else $error("P loop accumulator out of range");

endmodule
